// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies; the empty forms apply when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("concurrent assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- src/tcce_pkg.sv -----
// types and constants of the text console cell engine
// used by tcce_ctrl, tcce_datapath and text_console_cell_engine
package tcce_pkg;

  // width of a linear cell index before truncation (row field * column field)
  localparam int LIN_W = 14;

  localparam logic [7:0]  CH_TAB    = 8'h09;
  localparam logic [7:0]  CH_LF     = 8'h0A;
  localparam logic [7:0]  CH_FF     = 8'h0C;
  localparam logic [7:0]  CH_CR     = 8'h0D;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_QMARK  = 8'h3F;
  localparam logic [7:0]  CH_MIN    = 8'd32;
  localparam logic [7:0]  CH_MAX    = 8'd126;
  localparam logic [2:0]  TAB_STOP  = 3'd4;
  localparam logic [15:0] RESET_CELL = 16'h0F20;
  localparam logic [7:0]  ATTR_RESET = 8'h0F;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_PUT       = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_ENDLINE   = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  typedef enum logic [0:0] {
    REG_ATTRIBUTE      = 1'b0,
    REG_OUTPUT_ENABLED = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    CLS_IGNORE,
    CLS_CLEAR,
    CLS_NEWLINE,
    CLS_CR,
    CLS_CHAR,
    CLS_PUT,
    CLS_BACKSPACE,
    CLS_ENDLINE,
    CLS_READ
  } cls_e;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_IGNORE,
    DP_HOME_CLEAR,
    DP_NEWLINE,
    DP_CR,
    DP_WRAP_CLR,
    DP_PUT_CURSOR,
    DP_PUT_TARGET,
    DP_BACKSPACE,
    DP_READ,
    DP_SCROLL_START,
    DP_SCROLL_STEP,
    DP_FILL_START,
    DP_FILL_STEP,
    DP_INIT_STEP,
    DP_RESULT
  } dp_cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_PUT,
    ST_SCROLL_START,
    ST_SCROLL,
    ST_FILL_START,
    ST_FILL,
    ST_RESULT
  } state_e;

  typedef struct packed {
    cls_e cls;
    logic last_col;
    logic last_row;
    logic wrap;
    logic col_zero;
    logic tab_more;
    logic tab_left;
    logic sweep_last;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] char_byte;
    logic [5:0] target_row;
    logic [7:0] target_column;
  } tcce_req_t;

  typedef struct packed {
    logic [5:0]  cursor_row_out;
    logic [7:0]  cursor_column_out;
    logic [15:0] cell_value;
    logic        scrolled;
    logic        cleared;
    logic        ignored;
  } tcce_rsp_t;

endpackage

// ----- src/tcce_ctrl.sv -----
// controller state machine of the console engine
// depends on tcce_pkg; drives one datapath command per cycle
module tcce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tcce_pkg::dp_stat_t stat_i,
  output tcce_pkg::dp_cmd_e cmd_o,
  output logic              busy_o
);
  import tcce_pkg::*;

  state_e state_q, state_d;
  state_e after_put;

  // where to go after a cursor put: scroll, next tab space, or done
  always_comb begin
    if (stat_i.last_col && stat_i.last_row) begin
      after_put = ST_SCROLL_START;
    end else if (stat_i.tab_more) begin
      after_put = ST_PUT;
    end else begin
      after_put = ST_RESULT;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (stat_i.cls)
          CLS_CLEAR: state_d = ST_FILL;
          CLS_CHAR:  state_d = after_put;
          CLS_NEWLINE: begin
            state_d = stat_i.last_row ? ST_SCROLL_START : ST_RESULT;
          end
          CLS_ENDLINE: begin
            if (!stat_i.wrap && stat_i.last_row) begin
              state_d = ST_SCROLL_START;
            end else begin
              state_d = ST_RESULT;
            end
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_PUT:          state_d = after_put;
      ST_SCROLL_START: state_d = ST_SCROLL;
      ST_SCROLL: begin
        if (stat_i.sweep_last) state_d = ST_FILL_START;
      end
      ST_FILL_START:   state_d = ST_FILL;
      ST_FILL: begin
        if (stat_i.sweep_last) state_d = stat_i.tab_left ? ST_PUT : ST_RESULT;
      end
      ST_RESULT:       state_d = ST_IDLE;
      default:         state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = DP_NONE;
    unique case (state_q)
      ST_INIT: cmd_o = DP_INIT_STEP;
      ST_IDLE: cmd_o = start_i ? DP_CAPTURE : DP_NONE;
      ST_EXEC: begin
        unique case (stat_i.cls)
          CLS_IGNORE:    cmd_o = DP_IGNORE;
          CLS_CLEAR:     cmd_o = DP_HOME_CLEAR;
          CLS_NEWLINE:   cmd_o = DP_NEWLINE;
          CLS_CR:        cmd_o = DP_CR;
          CLS_CHAR:      cmd_o = DP_PUT_CURSOR;
          CLS_PUT:       cmd_o = DP_PUT_TARGET;
          CLS_BACKSPACE: cmd_o = stat_i.col_zero ? DP_NONE : DP_BACKSPACE;
          CLS_ENDLINE:   cmd_o = stat_i.wrap ? DP_WRAP_CLR : DP_NEWLINE;
          CLS_READ:      cmd_o = DP_READ;
          default:       cmd_o = DP_IGNORE;
        endcase
      end
      ST_PUT:          cmd_o = DP_PUT_CURSOR;
      ST_SCROLL_START: cmd_o = DP_SCROLL_START;
      ST_SCROLL:       cmd_o = DP_SCROLL_STEP;
      ST_FILL_START:   cmd_o = DP_FILL_START;
      ST_FILL:         cmd_o = DP_FILL_STEP;
      ST_RESULT:       cmd_o = DP_RESULT;
      default:         cmd_o = DP_NONE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/tcce_datapath.sv -----
// datapath of the console engine: cell memory, cursor, sweep pointer, result
// depends on tcce_pkg; steered by tcce_ctrl commands
module tcce_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcce_pkg::dp_cmd_e   cmd_i,
  input  tcce_pkg::tcce_req_t req_i,
  input  logic [7:0]          attr_i,
  input  logic                enable_i,
  output tcce_pkg::dp_stat_t  stat_o,
  output tcce_pkg::tcce_rsp_t rsp_o,
  output logic                strobe_o
);
  import tcce_pkg::*;

  localparam int Cells = ROWS * COLUMNS;
  localparam int AW    = $clog2(Cells);
  localparam logic [AW-1:0] LastCell  = AW'(Cells - 1);
  localparam logic [AW-1:0] ColsA     = AW'(COLUMNS);
  localparam logic [AW-1:0] BottomRow = AW'((ROWS - 1) * COLUMNS);
  localparam logic [5:0]    RowsW     = 6'(ROWS);
  localparam logic [5:0]    LastRow   = 6'(ROWS - 1);
  localparam logic [7:0]    ColsW     = 8'(COLUMNS);
  localparam logic [7:0]    LastCol   = 8'(COLUMNS - 1);

  logic [15:0] mem [Cells];

  tcce_req_t   req_q;
  tcce_rsp_t   rsp_q;
  logic [5:0]  row_q;
  logic [7:0]  col_q;
  logic        wrap_q;
  logic [2:0]  tab_cnt_q;
  logic [AW-1:0] ptr_q;
  logic        pend_q;
  logic [AW-1:0] pend_addr_q;
  logic [15:0] rdata_q;
  logic        scrolled_q, cleared_q, ignored_q, rd_q, strobe_q;

  cls_e        cls;
  logic        in_range;
  logic [2:0]  tab_init;
  logic [LIN_W-1:0] cur_lin, tgt_lin;
  logic [AW-1:0] addr_cur, addr_tgt;
  logic [7:0]  vis_ch, cur_ch, put_ch;
  logic [15:0] blank;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  assign in_range = (req_q.target_row < RowsW) && (req_q.target_column < ColsW);

  always_comb begin
    cls = CLS_IGNORE;
    if (req_q.op <= OP_ENDLINE && !enable_i) begin
      cls = CLS_IGNORE;
    end else begin
      unique case (req_q.op)
        OP_WRITE: begin
          unique case (req_q.char_byte)
            CH_FF:   cls = CLS_CLEAR;
            CH_LF:   cls = CLS_NEWLINE;
            CH_CR:   cls = CLS_CR;
            default: cls = CLS_CHAR;
          endcase
        end
        OP_PUT:       cls = in_range ? CLS_PUT : CLS_IGNORE;
        OP_BACKSPACE: cls = CLS_BACKSPACE;
        OP_ENDLINE:   cls = CLS_ENDLINE;
        OP_READ:      cls = in_range ? CLS_READ : CLS_IGNORE;
        default:      cls = CLS_IGNORE;
      endcase
    end
  end

  // number of cursor puts an incoming byte causes: a tab runs to the next stop
  always_comb begin
    tab_init = 3'd0;
    if (req_i.op == OP_WRITE) begin
      if (req_i.char_byte == CH_TAB) begin
        tab_init = TAB_STOP - {1'b0, col_q[1:0]};
      end else if (req_i.char_byte != CH_FF && req_i.char_byte != CH_LF &&
                   req_i.char_byte != CH_CR) begin
        tab_init = 3'd1;
      end
    end
  end

  assign cur_lin  = LIN_W'(row_q) * LIN_W'(ColsW) + LIN_W'(col_q);
  assign tgt_lin  = LIN_W'(req_q.target_row) * LIN_W'(ColsW) + LIN_W'(req_q.target_column);
  assign addr_cur = cur_lin[AW-1:0];
  assign addr_tgt = tgt_lin[AW-1:0];

  assign vis_ch = (req_q.char_byte >= CH_MIN && req_q.char_byte <= CH_MAX) ?
                  req_q.char_byte : CH_QMARK;
  assign cur_ch = (req_q.char_byte == CH_TAB) ? CH_SPACE : vis_ch;
  assign put_ch = (req_q.char_byte >= CH_MIN && req_q.char_byte <= CH_MAX) ?
                  req_q.char_byte : CH_SPACE;
  assign blank  = {attr_i, CH_SPACE};

  // a pending scroll copy owns the write port in the cycle after its read
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = blank;
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = rdata_q;
    end else begin
      unique case (cmd_i)
        DP_INIT_STEP: begin
          mem_we    = 1'b1;
          mem_wdata = RESET_CELL;
        end
        DP_FILL_STEP: mem_we = 1'b1;
        DP_PUT_CURSOR: begin
          mem_we    = 1'b1;
          mem_waddr = addr_cur;
          mem_wdata = {attr_i, cur_ch};
        end
        DP_PUT_TARGET: begin
          mem_we    = 1'b1;
          mem_waddr = addr_tgt;
          mem_wdata = {attr_i, put_ch};
        end
        DP_BACKSPACE: begin
          mem_we    = 1'b1;
          mem_waddr = addr_cur - AW'(1);
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  assign mem_raddr = (cmd_i == DP_SCROLL_STEP) ? ptr_q : addr_tgt;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= ptr_q - ColsA;
    if (cmd_i == DP_CAPTURE) req_q <= req_i;
    if (cmd_i == DP_RESULT) begin
      rsp_q.cursor_row_out    <= row_q;
      rsp_q.cursor_column_out <= col_q;
      rsp_q.cell_value        <= rd_q ? rdata_q : 16'd0;
      rsp_q.scrolled          <= scrolled_q;
      rsp_q.cleared           <= cleared_q;
      rsp_q.ignored           <= ignored_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      wrap_q     <= 1'b0;
      tab_cnt_q  <= '0;
      ptr_q      <= '0;
      pend_q     <= 1'b0;
      scrolled_q <= 1'b0;
      cleared_q  <= 1'b0;
      ignored_q  <= 1'b0;
      rd_q       <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      pend_q   <= (cmd_i == DP_SCROLL_STEP);
      strobe_q <= (cmd_i == DP_RESULT);
      unique case (cmd_i)
        DP_CAPTURE: begin
          tab_cnt_q  <= tab_init;
          scrolled_q <= 1'b0;
          cleared_q  <= 1'b0;
          ignored_q  <= 1'b0;
          rd_q       <= 1'b0;
        end
        DP_IGNORE: ignored_q <= 1'b1;
        DP_HOME_CLEAR: begin
          row_q     <= '0;
          col_q     <= '0;
          cleared_q <= 1'b1;
          ptr_q     <= '0;
        end
        DP_NEWLINE: begin
          col_q  <= '0;
          wrap_q <= 1'b0;
          if (row_q != LastRow) row_q <= row_q + 6'd1;
        end
        DP_CR: begin
          col_q  <= '0;
          wrap_q <= 1'b0;
        end
        DP_WRAP_CLR: wrap_q <= 1'b0;
        DP_PUT_CURSOR: begin
          wrap_q    <= (col_q == LastCol);
          tab_cnt_q <= tab_cnt_q - 3'd1;
          if (col_q == LastCol) begin
            col_q <= '0;
            if (row_q != LastRow) row_q <= row_q + 6'd1;
          end else begin
            col_q <= col_q + 8'd1;
          end
        end
        DP_BACKSPACE:    col_q <= col_q - 8'd1;
        DP_READ:         rd_q  <= 1'b1;
        DP_SCROLL_START: ptr_q <= ColsA;
        DP_FILL_START: begin
          ptr_q      <= BottomRow;
          scrolled_q <= 1'b1;
        end
        DP_SCROLL_STEP, DP_FILL_STEP, DP_INIT_STEP: ptr_q <= ptr_q + AW'(1);
        default: ;
      endcase
    end
  end

  assign stat_o.cls        = cls;
  assign stat_o.last_col   = (col_q == LastCol);
  assign stat_o.last_row   = (row_q == LastRow);
  assign stat_o.wrap       = wrap_q;
  assign stat_o.col_zero   = (col_q == 8'd0);
  assign stat_o.tab_more   = (tab_cnt_q > 3'd1);
  assign stat_o.tab_left   = (tab_cnt_q != 3'd0);
  assign stat_o.sweep_last = (ptr_q == LastCell);

  assign rsp_o    = rsp_q;
  assign strobe_o = strobe_q;

endmodule

// ----- src/text_console_cell_engine.sv -----
// top level of the text console cell engine: apb registers, controller, datapath
// depends on tcce_pkg, tcce_ctrl, tcce_datapath and assert_macros.svh
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+----------------------------
//  request   | start, busy, req_i                       | taken when start && !busy
//  result    | result_strobe_o, result_o                | one cycle, cannot be stalled
//  config    | psel, penable, pwrite, paddr, pwdata ... | apb write, pready tied high
//
//  after reset a clearing pass writes every cell, busy high
//  a plain byte, cr, backspace, put or read passes the exec and result states between accepts
//  a tab adds one put per extra space; one cell write per cycle sets the pace
//  a scroll copies one cell per cycle and then blanks the bottom row, a form feed
//  clears one cell per cycle
//  the result strobe shows while the next request may already be accepted
module text_console_cell_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                start,
  output logic                busy,
  input  tcce_pkg::tcce_req_t req_i,
  // result channel
  output logic                result_strobe_o,
  output tcce_pkg::tcce_rsp_t result_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tcce_pkg::*;
  `include "assert_macros.svh"

  logic [7:0] attr_q;
  logic       enable_q;
  logic       cfg_wr;
  reg_idx_e   reg_idx;

  dp_cmd_e    cmd;
  dp_stat_t   stat;

  // register i sits at byte address 4*i
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_ATTRIBUTE:      prdata = {24'd0, attr_q};
      REG_OUTPUT_ENABLED: prdata = {31'd0, enable_q};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q   <= ATTR_RESET;
      enable_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ATTRIBUTE:      attr_q   <= pwdata[7:0];
        REG_OUTPUT_ENABLED: enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // sequencer: one datapath command per cycle
  tcce_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // cell memory, cursor state and result register
  tcce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (req_i),
    .attr_i   (attr_q),
    .enable_i (enable_q),
    .stat_o   (stat),
    .rsp_o    (result_o),
    .strobe_o (result_strobe_o)
  );

  // a result only comes out once the controller is back to waiting
  `ASSERT_NEVER(a_strobe_busy, clk_i, rst_ni, result_strobe_o && busy)
  // an accepted request never yields its result in the very next cycle
  `ASSERT_PROP(a_no_early_result, clk_i, rst_ni, (start && !busy) |=> !result_strobe_o)
  // the reported cursor always lies on the screen
  `ASSERT_NEVER(a_cursor_range, clk_i, rst_ni, result_strobe_o &&
                ((result_o.cursor_row_out >= 6'(ROWS)) ||
                 (result_o.cursor_column_out >= 8'(COLUMNS))))
  // a form feed never scrolls
  `ASSERT_NEVER(a_clear_no_scroll, clk_i, rst_ni,
                result_strobe_o && result_o.cleared && result_o.scrolled)

endmodule

// ----- dv/tb_text_console_cell_engine.sv -----
// self-checking testbench of text_console_cell_engine: directed and random console requests
// depends on tcce_pkg and the engine rtl; holds its own screen model to predict every result
module tb_text_console_cell_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int NCELLS  = ROWS * COLUMNS;

  // request waiting in the backlog, optionally held until all results are back
  typedef struct {
    tcce_req_t rq;
    bit        drain_first;
  } backlog_t;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  tcce_req_t   req_d   = '0;
  logic        result_strobe_o;
  tcce_rsp_t   result_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // screen model: cells, cursor, wrap flag and the two registers
  logic [15:0] screen_mem [NCELLS];
  int          cur_row;
  int          cur_col;
  bit          wrap_flag;
  bit          scroll_seen;
  logic [7:0]  attr_reg;
  logic        out_en;

  backlog_t    req_backlog_q[$];
  tcce_rsp_t   cell_rsp_q[$];
  backlog_t    nxt;
  tcce_rsp_t   predicted;
  tcce_rsp_t   want_rsp;
  int unsigned idle_pct = 19;
  int unsigned queued_cnt, accepted_cnt, read_cnt, scroll_cnt, clear_cnt, ignore_cnt;
  int unsigned reg_write_cnt, fail_cnt;

  text_console_cell_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_d),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop far beyond the slowest legal run (every request scrolling or clearing)
  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // screen model
  // ---------------------------------------------------------------------------

  // cursor to the start of the next row, scrolling one row up at the bottom
  function automatic void line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = COLUMNS; i < NCELLS; i++) screen_mem[i - COLUMNS] = screen_mem[i];
      cur_row = ROWS - 1;
      // blank bottom row takes the current attribute
      for (int x = 0; x < COLUMNS; x++) screen_mem[cur_row * COLUMNS + x] = {attr_reg, CH_SPACE};
      scroll_seen = 1'b1;
    end
  endfunction

  // store one byte at the cursor, unprintable shown as a question mark
  function automatic void store_char(logic [7:0] b);
    logic [7:0] shown;
    shown = (b >= CH_MIN && b <= CH_MAX) ? b : CH_QMARK;
    wrap_flag = 1'b0;
    screen_mem[cur_row * COLUMNS + cur_col] = {attr_reg, shown};
    cur_col++;
    // storing into the last column forces a newline and marks the wrap
    if (cur_col >= COLUMNS) begin
      line_feed();
      wrap_flag = 1'b1;
    end
  endfunction

  // expected result of one request, updating the screen model
  function automatic tcce_rsp_t console_apply(tcce_req_t rq);
    tcce_rsp_t  rs;
    int         spaces;
    int         idx;
    bit         in_range;
    logic [7:0] ch;
    rs          = '0;
    scroll_seen = 1'b0;
    in_range    = (int'(rq.target_row) < ROWS) && (int'(rq.target_column) < COLUMNS);
    idx         = int'(rq.target_row) * COLUMNS + int'(rq.target_column);
    if (rq.op <= OP_ENDLINE && !out_en) begin
      // output disabled: everything but a read is dropped
      rs.ignored = 1'b1;
    end else begin
      case (rq.op)
        OP_WRITE: begin
          case (rq.char_byte)
            CH_FF: begin
              for (int i = 0; i < NCELLS; i++) screen_mem[i] = {attr_reg, CH_SPACE};
              cur_row    = 0;
              cur_col    = 0;
              rs.cleared = 1'b1;
            end
            CH_LF: begin
              line_feed();
              wrap_flag = 1'b0;
            end
            CH_CR: begin
              cur_col   = 0;
              wrap_flag = 1'b0;
            end
            CH_TAB: begin
              // spaces up to the next tab stop, each may wrap or scroll
              spaces = int'(TAB_STOP) - cur_col % int'(TAB_STOP);
              repeat (spaces) store_char(CH_SPACE);
            end
            default: store_char(rq.char_byte);
          endcase
        end
        OP_PUT: begin
          if (!in_range) begin
            rs.ignored = 1'b1;
          end else begin
            ch = (rq.char_byte >= CH_MIN && rq.char_byte <= CH_MAX) ? rq.char_byte : CH_SPACE;
            screen_mem[idx] = {attr_reg, ch};
          end
        end
        OP_BACKSPACE: begin
          // at column 0 nothing happens and nothing is flagged
          if (cur_col != 0) begin
            cur_col--;
            screen_mem[cur_row * COLUMNS + cur_col] = {attr_reg, CH_SPACE};
          end
        end
        OP_ENDLINE: begin
          // a line that just wrapped is already ended
          if (!wrap_flag) line_feed();
          wrap_flag = 1'b0;
        end
        OP_READ: begin
          if (!in_range) rs.ignored = 1'b1;
          else rs.cell_value = screen_mem[idx];
        end
        default: rs.ignored = 1'b1;
      endcase
    end
    rs.cursor_row_out    = 6'(cur_row);
    rs.cursor_column_out = 8'(cur_col);
    rs.scrolled          = scroll_seen;
    return rs;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: one request per accept, idling at random between requests
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // request taken at this edge: predict its result now, in accept order
      if (start && !busy) begin
        predicted = console_apply(req_d);
        cell_rsp_q.push_back(predicted);
        accepted_cnt++;
        if (req_d.op == OP_READ) read_cnt++;
        scroll_cnt += predicted.scrolled;
        clear_cnt  += predicted.cleared;
        ignore_cnt += predicted.ignored;
      end
      // free to present the next request (start held while busy)
      if (!start || !busy) begin
        if (req_backlog_q.size() != 0 &&
            !(req_backlog_q[0].drain_first && cell_rsp_q.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          nxt   = req_backlog_q.pop_front();
          req_d <= nxt.rq;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: the strobe cannot be stalled, every strobe is one result
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (cell_rsp_q.size() == 0) begin
        $error("result with no request outstanding: %p", result_o);
        fail_cnt++;
      end else begin
        want_rsp = cell_rsp_q.pop_front();
        check_field("cursor_row_out", 16'(want_rsp.cursor_row_out),
                    16'(result_o.cursor_row_out));
        check_field("cursor_column_out", 16'(want_rsp.cursor_column_out),
                    16'(result_o.cursor_column_out));
        check_field("cell_value", want_rsp.cell_value, result_o.cell_value);
        check_field("scrolled", 16'(want_rsp.scrolled), 16'(result_o.scrolled));
        check_field("cleared", 16'(want_rsp.cleared), 16'(result_o.cleared));
        check_field("ignored", 16'(want_rsp.ignored), 16'(result_o.ignored));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic tcce_req_t mk(logic [2:0] op, logic [7:0] ch, logic [5:0] row,
                                   logic [7:0] col);
    tcce_req_t rq;
    rq.op            = op;
    rq.char_byte     = ch;
    rq.target_row    = row;
    rq.target_column = col;
    return rq;
  endfunction

  function automatic void push_req(tcce_req_t rq, bit drain);
    backlog_t b;
    b.rq          = rq;
    b.drain_first = drain;
    req_backlog_q.push_back(b);
    queued_cnt++;
  endfunction

  // one request from the middle of a line of text
  function automatic tcce_req_t rand_body_req();
    tcce_req_t   rq;
    int unsigned pick;
    rq.op            = OP_WRITE;
    rq.char_byte     = 8'($urandom_range(255));
    // mostly on screen, now and then anywhere in the field range
    rq.target_row    = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
                                                 : 6'($urandom_range(ROWS - 1));
    rq.target_column = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(COLUMNS - 1));
    pick = $urandom_range(99);
    if (pick < 55) rq.char_byte = 8'($urandom_range(126, 32));
    else if (pick < 61) rq.op = OP_WRITE;  // any byte, control codes included
    else if (pick < 66) rq.char_byte = CH_TAB;
    else if (pick < 73) rq.op = OP_PUT;
    else if (pick < 78) rq.op = OP_BACKSPACE;
    else if (pick < 92) rq.op = OP_READ;
    else if (pick < 94) rq.op = 3'($urandom_range(7, 5));  // codes with no meaning
    else rq.char_byte = CH_CR;
    return rq;
  endfunction

  // a line of text, long ones wrap, then a line ending
  task automatic queue_random_line(bit drain);
    int          len;
    int unsigned pick;
    tcce_req_t   rq;
    len = ($urandom_range(5) == 0) ? $urandom_range(100, 60) : $urandom_range(25);
    for (int i = 0; i < len; i++) push_req(rand_body_req(), drain && i == 0);
    rq   = rand_body_req();
    pick = $urandom_range(19);
    rq.op = OP_WRITE;
    if (pick < 8) rq.char_byte = CH_LF;
    else if (pick < 13) rq.op = OP_ENDLINE;
    else if (pick < 16) rq.char_byte = CH_CR;
    else if (pick < 19) rq.char_byte = 8'($urandom_range(126, 32));
    else rq.char_byte = CH_FF;
    push_req(rq, 1'b0);
  endtask

  // run of newlines and line ends that pushes the cursor toward the bottom
  task automatic queue_newline_burst();
    tcce_req_t rq;
    repeat ($urandom_range(20, 5)) begin
      rq = rand_body_req();
      rq.op = ($urandom_range(1) == 0) ? OP_WRITE : OP_ENDLINE;
      rq.char_byte = CH_LF;
      push_req(rq, 1'b0);
    end
  endtask

  // wait until every request is taken and every result is back
  task automatic drain_all();
    while (req_backlog_q.size() != 0 || start || cell_rsp_q.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random_phase(int unsigned sender_idle, int unsigned n_items);
    int unsigned goal;
    idle_pct = sender_idle;
    goal     = queued_cnt + n_items;
    while (queued_cnt < goal) begin
      if ($urandom_range(7) == 0) queue_newline_burst();
      else queue_random_line($urandom_range(9) == 0);
    end
    drain_all();
  endtask

  // apb write then read back, model follows the write (engine is idle here)
  task automatic reg_write(reg_idx_e idx, logic [31:0] word);
    logic [31:0] want;
    logic [31:0] got;
    case (idx)
      REG_ATTRIBUTE: begin
        attr_reg = word[7:0];
        want     = {24'd0, word[7:0]};
      end
      default: begin
        out_en = word[0];
        want   = {31'd0, word[0]};
      end
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_write_cnt++;
    if (got !== want) begin
      $error("%s readback mismatch: expected %0h, got %0h", idx.name(), want, got);
      fail_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // model reset state: white spaces, cursor home, default registers
    for (int i = 0; i < NCELLS; i++) screen_mem[i] = RESET_CELL;
    cur_row   = 0;
    cur_col   = 0;
    wrap_flag = 1'b0;
    attr_reg  = ATTR_RESET;
    out_en    = 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: control codes, printable limits, position limits, odd op codes
    push_req(mk(OP_WRITE, CH_FF, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_WRITE, CH_MIN, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_WRITE, CH_MAX, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_WRITE, 8'd31, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_WRITE, 8'd127, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_WRITE, 8'hFF, 6'h3F, 8'hFF), 1'b0);
    push_req(mk(OP_WRITE, 8'h00, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_WRITE, CH_TAB, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_BACKSPACE, 8'd0, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_WRITE, CH_CR, 6'd0, 8'd0), 1'b0);
    // backspace at column 0 does nothing
    push_req(mk(OP_BACKSPACE, 8'd0, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_ENDLINE, 8'd0, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_WRITE, CH_LF, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_PUT, 8'h41, 6'd0, 8'd0), 1'b0);
    // unprintable put lands as a space in the far corner
    push_req(mk(OP_PUT, 8'h80, 6'(ROWS - 1), 8'(COLUMNS - 1)), 1'b0);
    push_req(mk(OP_PUT, 8'hFF, 6'h3F, 8'd0), 1'b0);
    // sender holds this read until the earlier results are back
    push_req(mk(OP_READ, 8'd0, 6'd0, 8'd0), 1'b1);
    push_req(mk(OP_READ, 8'hFF, 6'(ROWS - 1), 8'(COLUMNS - 1)), 1'b0);
    push_req(mk(OP_READ, 8'd0, 6'h3F, 8'hFF), 1'b0);
    push_req(mk(3'd7, 8'hFF, 6'h3F, 8'hFF), 1'b0);
    push_req(mk(3'd5, 8'h00, 6'd0, 8'd0), 1'b0);
    drain_all();

    // output disabled: writes dropped, form feed too, reads still served
    reg_write(REG_OUTPUT_ENABLED, 32'd0);
    push_req(mk(OP_WRITE, 8'h78, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_WRITE, CH_FF, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_PUT, 8'h41, 6'd1, 8'd1), 1'b0);
    push_req(mk(OP_ENDLINE, 8'd0, 6'd0, 8'd0), 1'b0);
    push_req(mk(OP_READ, 8'd0, 6'd0, 8'd0), 1'b0);
    drain_all();
    reg_write(REG_OUTPUT_ENABLED, 32'hFFFF_FFFF);
    reg_write(REG_ATTRIBUTE, 32'h0000_00FF);

    // random text, sender idles now and then
    run_random_phase(19, 110);

    // attribute all zero, then a short stretch with output disabled
    reg_write(REG_ATTRIBUTE, 32'h0000_0000);
    reg_write(REG_OUTPUT_ENABLED, 32'hFFFF_FFFE);
    idle_pct = 19;
    repeat (20) push_req(rand_body_req(), 1'b0);
    queue_newline_burst();
    drain_all();
    reg_write(REG_OUTPUT_ENABLED, 32'd1);

    // sender mostly idle
    run_random_phase(87, 100);

    // random attribute, back to back requests
    reg_write(REG_ATTRIBUTE, $urandom);
    run_random_phase(0, 100);

    // let any stray strobe show before judging
    repeat (NCELLS + 16) @(posedge clk_i);

    $display("run covered %0d requests (%0d reads, %0d ignored), %0d scrolls, %0d clears",
             accepted_cnt, read_cnt, ignore_cnt, scroll_cnt, clear_cnt);
    $display("with %0d register writes across attribute 0x00/0xff/random and output off",
             reg_write_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
